// ----- hw/rtl/mexp_pkg.sv -----
// Shared definitions for the modular exponentiation core.
// Holds register reset values, configuration indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int unsigned WIDTH_DEFAULT = 32;

  // Register reset values before truncation to the datapath width.
  localparam logic [63:0] MODULUS_RESET  = 64'd100760483;
  localparam logic [63:0] EXPONENT_RESET = 64'd18427;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

  // Exponentiation sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_SQUARE = 5'b00100,
    ST_MULT   = 5'b01000,
    ST_DONE   = 5'b10000
  } mexp_state_e;

endpackage

// ----- hw/rtl/mexp_modmul.sv -----
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
// Shared by base reduction, squaring and multiplying. Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_modmul
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int unsigned CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_TOP = CW'(WIDTH - 1);

  // (x + y) mod m for x, y < m; the extra bit keeps the carry.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WIDTH-1:0];
  endfunction

  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] r_q, r_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] dbl;

  assign dbl = add_mod(r_q, r_q, m_i);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
      cnt_d  = CNT_TOP;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // double, then add a when the top bit of b is set
      r_d = b_q[WIDTH-1] ? add_mod(dbl, a_q, m_i) : dbl;
      b_d = {b_q[WIDTH-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

// ----- hw/rtl/mexp_seq.sv -----
// Square-and-multiply sequencer: reduces the base, then walks the exponent
// from the top bit, issuing products to the shared multiplier. Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_seq
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] base_i,
  input  logic [WIDTH-1:0] modulus_i,
  input  logic [WIDTH-1:0] exponent_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [WIDTH-1:0] res_o,
  output logic             mm_start_o,
  output logic [WIDTH-1:0] mm_a_o,
  output logic [WIDTH-1:0] mm_b_o,
  input  logic             mm_done_i,
  input  logic [WIDTH-1:0] mm_prod_i
);

  localparam int unsigned CW = $clog2(WIDTH);
  localparam logic [CW-1:0] IDX_TOP = CW'(WIDTH - 1);

  mexp_state_e      state_q, state_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] base_r_q, base_r_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [WIDTH-1:0] one_m;
  logic             mod_zero;

  assign mod_zero = (modulus_i == '0);
  // 1 mod m: zero when the modulus is one
  assign one_m    = (modulus_i == WIDTH'(1)) ? '0 : WIDTH'(1);

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    base_r_d   = base_r_q;
    idx_d      = idx_q;
    mm_start_o = 1'b0;
    mm_a_o     = acc_q;
    mm_b_o     = acc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_d = IDX_TOP;
          if (mod_zero) begin
            acc_d   = '0;
            state_d = ST_DONE;
          end else begin
            // reduce the base as one_m * base mod m
            acc_d      = one_m;
            mm_start_o = 1'b1;
            mm_a_o     = one_m;
            mm_b_o     = base_i;
            state_d    = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done_i) begin
          base_r_d   = mm_prod_i;
          mm_start_o = 1'b1;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mm_done_i) begin
          acc_d = mm_prod_i;
          if (exponent_i[idx_q]) begin
            mm_start_o = 1'b1;
            mm_a_o     = mm_prod_i;
            mm_b_o     = base_r_q;
            state_d    = ST_MULT;
          end else if (idx_q == '0) begin
            state_d = ST_DONE;
          end else begin
            idx_d      = idx_q - CW'(1);
            mm_start_o = 1'b1;
            mm_a_o     = mm_prod_i;
            mm_b_o     = mm_prod_i;
          end
        end
      end
      ST_MULT: begin
        if (mm_done_i) begin
          acc_d = mm_prod_i;
          if (idx_q == '0) begin
            state_d = ST_DONE;
          end else begin
            idx_d      = idx_q - CW'(1);
            mm_start_o = 1'b1;
            mm_a_o     = mm_prod_i;
            mm_b_o     = mm_prod_i;
            state_d    = ST_SQUARE;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    base_r_q <= base_r_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = acc_q;

endmodule

// ----- hw/rtl/modular_exponentiation_core.sv -----
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    base_i
// out      output     out_valid_o / out_ready_i  result_o
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// The bit-serial modular multiplier, one bit per cycle, sets the time to a result: the
// sequencer reduces the base, then squares once per exponent bit and multiplies once
// per set bit. A zero modulus answers with zero without using the multiplier.
// Reset loads the modulus and exponent defaults; no clearing pass is needed.
// The result register frees the sequencer while out stalls; in stays low until
// the current item has moved into the result register.
// Depends on mexp_pkg, mexp_seq and mexp_modmul.
`timescale 1ns / 1ps

module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WIDTH-1:0]     base_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WIDTH-1:0]     result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WIDTH-1:0]     cfg_data_i
);

  logic [WIDTH-1:0] modulus_q, exponent_q;
  logic [WIDTH-1:0] result_q;
  logic             out_valid_q, out_valid_d;
  logic             res_valid, res_ready;
  logic [WIDTH-1:0] res;
  logic             mm_start, mm_done;
  logic [WIDTH-1:0] mm_a, mm_b, mm_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WIDTH'(MODULUS_RESET);
      exponent_q <= WIDTH'(EXPONENT_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS:  modulus_q  <= cfg_data_i;
        CFG_EXPONENT: exponent_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mexp_seq #(
    .WIDTH(WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .base_i     (base_i),
    .modulus_i  (modulus_q),
    .exponent_i (exponent_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mm_start_o (mm_start),
    .mm_a_o     (mm_a),
    .mm_b_o     (mm_b),
    .mm_done_i  (mm_done),
    .mm_prod_i  (mm_prod)
  );

  mexp_modmul #(
    .WIDTH(WIDTH)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .m_i    (modulus_q),
    .done_o (mm_done),
    .prod_o (mm_prod)
  );

  // Load the result register when it is empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      result_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ----- hw/rtl/mexp_checker.sv -----
// Port-level checks for the modular exponentiation core, bound to the top level.
// Depends on mexp_pkg and modular_exponentiation_core.
`timescale 1ns / 1ps

module mexp_checker
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [WIDTH-1:0]     base_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [WIDTH-1:0]     result_o,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [WIDTH-1:0]     cfg_data_i
);

  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o high right after an item was accepted");

  // A new result appears only when the sequencer had been busy.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised without an item in flight");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result dropped or changed while stalled");

  // A waiting input item holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(base_i))
    else $error("input item dropped or changed while waiting");

  // Configuration writes land only on an idle block with known index and data.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> in_ready_o && !out_valid_o && !$isunknown({cfg_idx_i, cfg_data_i}))
    else $error("configuration written while an item was in flight");

endmodule

bind modular_exponentiation_core mexp_checker #(
  .WIDTH(WIDTH)
) u_mexp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .base_i     (base_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .result_o   (result_o),
  .cfg_we_i   (cfg_we_i),
  .cfg_idx_i  (cfg_idx_i),
  .cfg_data_i (cfg_data_i)
);
